[hw/rtl/vrfp_pkg.sv]
package vrfp_pkg;

    localparam logic [4:0] FRAME_LEN = 5'd16;
    localparam logic [4:0] SUM_POS   = 5'd14;
    localparam logic [7:0] LEN_VALUE = 8'd15;
    localparam logic [7:0] CMD_RF     = 8'h72;
    localparam logic [7:0] CMD_STATUS = 8'h76;
    localparam logic [7:0] CMD_SENSOR = 8'h73;

    localparam int W_MINF = 0;
    localparam int W_MAXF = 1;
    localparam int W_MAXP = 2;
    localparam int W_FREQ = 3;
    localparam int W_SETP = 4;
    localparam int W_ACTP = 5;
    localparam int W_PIT  = 6;
    localparam int W_TEMP = 7;
    localparam int NUM_WORDS = 8;

    typedef enum logic [2:0] {
        ST_ACCEPTED  = 3'd0,
        ST_IGNORED   = 3'd1,
        ST_LEN_ERR   = 3'd2,
        ST_SUM_ERR   = 3'd3,
        ST_END_ERR   = 3'd4,
        ST_DONE      = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        KIND_OTHER  = 2'd0,
        KIND_RF     = 2'd1,
        KIND_STATUS = 2'd2,
        KIND_SENSOR = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        PH_COLLECT = 2'd0,
        PH_DONE    = 2'd1,
        PH_ERROR   = 2'd2
    } t_phase;

    typedef struct packed {
        t_status     status;
        t_kind       frame_kind;
        logic [15:0] min_frequency;
        logic [15:0] max_frequency;
        logic [15:0] power_limit;
        logic [15:0] frequency;
        logic [15:0] set_power;
        logic [15:0] output_power;
        logic [7:0]  pit_flag;
        logic [15:0] temperature;
    } t_result;

    typedef struct packed {
        t_phase     phase;
        logic [4:0] count;
    } t_core_stat;

endpackage

[hw/rtl/vrfp_in_if.sv]
interface vrfp_in_if ();
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] rx_byte;

    modport source (output valid, output mode, output rx_byte, input ready);
    modport sink   (input valid, input mode, input rx_byte, output ready);
endinterface

[hw/rtl/vrfp_out_if.sv]
interface vrfp_out_if ();
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [1:0]  frame_kind;
    logic [15:0] min_frequency;
    logic [15:0] max_frequency;
    logic [15:0] power_limit;
    logic [15:0] frequency;
    logic [15:0] set_power;
    logic [15:0] output_power;
    logic [7:0]  pit_flag;
    logic [15:0] temperature;

    modport source (
        output valid, output status, output frame_kind,
        output min_frequency, output max_frequency, output power_limit,
        output frequency, output set_power, output output_power,
        output pit_flag, output temperature,
        input ready
    );
    modport sink (
        input valid, input status, input frame_kind,
        input min_frequency, input max_frequency, input power_limit,
        input frequency, input set_power, input output_power,
        input pit_flag, input temperature,
        output ready
    );
endinterface

[hw/rtl/vtx_reply_frame_parser.sv]
// Channel  Dir  Payload                                      Transfer
// i_rx     in   mode, rx_byte                                valid & ready
// o_res    out  status, frame_kind, eight held words         valid & ready
//
// One result per input transfer, one transfer per cycle when o_res keeps up.
// Parser state updates in the accepting cycle; the result is registered in the
// output register, or in the skid stage while o_res stalls. A two-entry output
// buffer (register plus skid stage) keeps i_rx ready for one more byte while a
// result waits; i_rx.ready drops only when both entries are full. Synchronous
// active-low reset clears the parser state and zeroes the held words.
module vtx_reply_frame_parser import vrfp_pkg::*; (
    input logic          i_clk,
    input logic          i_rst_n,
    vrfp_in_if.sink      i_rx,
    vrfp_out_if.source   o_res
);

    t_result    w_result;
    t_result    w_out;
    t_core_stat w_stat;
    logic       w_fire;

    assign w_fire = i_rx.valid && i_rx.ready;

    vrfp_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (w_fire),
        .i_mode    (i_rx.mode),
        .i_rx_byte (i_rx.rx_byte),
        .o_result  (w_result),
        .o_stat    (w_stat)
    );

    vrfp_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_rx.valid),
        .o_ready (i_rx.ready),
        .i_data  (w_result),
        .o_valid (o_res.valid),
        .i_ready (o_res.ready),
        .o_data  (w_out)
    );

    assign o_res.status        = w_out.status;
    assign o_res.frame_kind    = w_out.frame_kind;
    assign o_res.min_frequency = w_out.min_frequency;
    assign o_res.max_frequency = w_out.max_frequency;
    assign o_res.power_limit   = w_out.power_limit;
    assign o_res.frequency     = w_out.frequency;
    assign o_res.set_power     = w_out.set_power;
    assign o_res.output_power  = w_out.output_power;
    assign o_res.pit_flag      = w_out.pit_flag;
    assign o_res.temperature   = w_out.temperature;

    a_kind_only_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.status != ST_DONE) |-> (o_res.frame_kind == KIND_OTHER))
        else $error("frame kind set on a result that is not frame done");

    a_arm_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && i_rx.mode) |=> (w_stat.count == 5'd0 && w_stat.phase == PH_COLLECT))
        else $error("arm did not restart the parser");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.count <= FRAME_LEN)
        else $error("byte count beyond frame length");

    a_stall_means_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_rx.ready |-> o_res.valid)
        else $error("input stalled while output register is empty");

endmodule

[hw/rtl/vrfp_core.sv]
module vrfp_core import vrfp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic       i_mode,
    input  logic [7:0] i_rx_byte,
    output t_result    o_result,
    output t_core_stat o_stat
);

    logic [4:0]  r_count, n_count;
    t_phase      r_phase, n_phase;
    logic [7:0]  r_sum, n_sum;
    logic [7:0]  r_frame [1:9];
    logic [15:0] r_words [NUM_WORDS];
    logic [15:0] n_words [NUM_WORDS];
    logic        n_store;
    t_status     n_status;
    t_kind       n_kind;

    always_comb begin
        n_count  = r_count;
        n_phase  = r_phase;
        n_sum    = r_sum;
        n_store  = 1'b0;
        n_status = ST_ACCEPTED;
        n_kind   = KIND_OTHER;
        for (int k = 0; k < NUM_WORDS; k++) begin
            n_words[k] = r_words[k];
        end
        if (i_mode) begin
            n_count = '0;
            n_phase = PH_COLLECT;
        end else if (r_phase != PH_COLLECT || r_count >= FRAME_LEN) begin
            n_status = ST_IGNORED;
        end else begin
            if (r_count == 5'd0) begin
                if (i_rx_byte != LEN_VALUE) begin
                    n_phase  = PH_ERROR;
                    n_status = ST_LEN_ERR;
                end
                n_sum = '0;
            end else if (r_count < SUM_POS) begin
                n_sum   = r_sum + i_rx_byte;
                n_store = (r_count <= 5'd9);
            end else if (r_count == SUM_POS) begin
                if (r_sum != i_rx_byte) begin
                    n_phase  = PH_ERROR;
                    n_status = ST_SUM_ERR;
                end
            end else if (i_rx_byte != 8'd0) begin
                n_phase  = PH_ERROR;
                n_status = ST_END_ERR;
            end else begin
                n_phase  = PH_DONE;
                n_status = ST_DONE;
                case (r_frame[1])
                    CMD_RF: begin
                        n_kind          = KIND_RF;
                        n_words[W_MINF] = {r_frame[3], r_frame[2]};
                        n_words[W_MAXF] = {r_frame[5], r_frame[4]};
                        n_words[W_MAXP] = {r_frame[7], r_frame[6]};
                    end
                    CMD_STATUS: begin
                        n_kind          = KIND_STATUS;
                        n_words[W_FREQ] = {r_frame[3], r_frame[2]};
                        n_words[W_SETP] = {r_frame[5], r_frame[4]};
                        n_words[W_PIT]  = {8'h00, r_frame[7]};
                        n_words[W_ACTP] = {r_frame[9], r_frame[8]};
                    end
                    CMD_SENSOR: begin
                        n_kind          = KIND_SENSOR;
                        n_words[W_TEMP] = {r_frame[7], r_frame[6]};
                    end
                    default: begin
                        n_kind = KIND_OTHER;
                    end
                endcase
            end
            n_count = r_count + 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_phase <= PH_COLLECT;
            r_sum   <= '0;
            for (int k = 0; k < NUM_WORDS; k++) begin
                r_words[k] <= '0;
            end
        end else if (i_fire) begin
            r_count <= n_count;
            r_phase <= n_phase;
            r_sum   <= n_sum;
            for (int k = 0; k < NUM_WORDS; k++) begin
                r_words[k] <= n_words[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire && n_store) begin
            r_frame[r_count[3:0]] <= i_rx_byte;
        end
    end

    always_comb begin
        o_result.status        = n_status;
        o_result.frame_kind    = n_kind;
        o_result.min_frequency = n_words[W_MINF];
        o_result.max_frequency = n_words[W_MAXF];
        o_result.power_limit   = n_words[W_MAXP];
        o_result.frequency     = n_words[W_FREQ];
        o_result.set_power     = n_words[W_SETP];
        o_result.output_power  = n_words[W_ACTP];
        o_result.pit_flag      = n_words[W_PIT][7:0];
        o_result.temperature   = n_words[W_TEMP];
    end

    assign o_stat.phase = r_phase;
    assign o_stat.count = r_count;

endmodule

[hw/rtl/vrfp_skid.sv]
module vrfp_skid import vrfp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_result i_data,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data
);

    logic    r_out_v;
    logic    r_skid_v;
    t_result r_out;
    t_result r_skid;
    logic    w_fire;
    logic    w_drain;

    assign o_ready = !r_skid_v;
    assign w_fire  = i_valid && !r_skid_v;
    assign w_drain = !r_out_v || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (w_drain) begin
            r_out_v  <= r_skid_v || w_fire;
            r_skid_v <= 1'b0;
        end else if (w_fire) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_drain) begin
            r_out <= r_skid_v ? r_skid : i_data;
        end else if (w_fire) begin
            r_skid <= i_data;
        end
    end

    assign o_valid = r_out_v;
    assign o_data  = r_out;

endmodule
